>>> rtl/core/rgbf_pkg.sv
package rgbf_pkg;

    // Default number of colour steps in one fade.
    localparam int unsigned FADE_STEPS_DEF = 32;

    // Operation codes carried in the op field of an input word.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_PULSE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_UPDATE_PERIOD  = 1'b0;
    localparam logic REG_PULSE_DURATION = 1'b1;

    // Configuration reset values, in milliseconds.
    localparam logic [15:0] UPDATE_PERIOD_RST  = 16'd20;
    localparam logic [15:0] PULSE_DURATION_RST = 16'd1000;

    // One colour: element 0 is red, 1 is green, 2 is blue.
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       updated;
        logic       fade_done;
        logic       pulse_active;
    } t_out_word;

endpackage

>>> rtl/core/rgbf_lerp.sv
// One colour channel of the fade: start plus the signed product of step
// index and colour difference, divided by the step count minus one with the
// quotient truncated toward zero. The division is a multiply by a rounded-up
// reciprocal, exact for every product magnitude the channel can present.
module rgbf_lerp
    import rgbf_pkg::*;
#(
    parameter int unsigned FADE_STEPS = FADE_STEPS_DEF
) (
    input  logic [7:0]                        i_start,
    input  logic [$clog2(FADE_STEPS)+7:0]     i_mag,
    input  logic                              i_neg,
    output logic [7:0]                        o_value
);

    localparam int unsigned IW  = $clog2(FADE_STEPS);
    localparam int unsigned PW  = IW + 8;
    localparam int unsigned RS  = PW + 8;
    localparam int unsigned DIV = FADE_STEPS - 1;
    localparam longint unsigned RECIP_L = ((64'd1 << RS) + DIV - 1) / DIV;
    localparam logic [RS:0] RECIP = RECIP_L[RS:0];

    logic [PW+RS:0] w_prod;
    logic [7:0]     w_quot;

    assign w_prod  = {{(RS + 1){1'b0}}, i_mag} * {{PW{1'b0}}, RECIP};
    assign w_quot  = w_prod[RS +: 8];
    assign o_value = i_neg ? (i_start - w_quot) : (i_start + w_quot);

endmodule

>>> rtl/core/rgb_fade_pulse_controller_core.sv
// RGB fade and pulse controller. Each input word is a one-millisecond tick,
// a new target colour, or a pulse colour, and each word yields exactly one
// result word with the shown colour and the updated, fade_done and
// pulse_active flags. A new target takes the shown colour as its fade start;
// every update_period_ms ticks the next of FADE_STEPS linearly interpolated
// colours is shown, and a pulse returns the target to black once
// pulse_duration_ms has passed. Words pass through an input register and an
// output register, so the block takes one word per clock while the output is
// not held back; while a result waits at the output one more word can still
// be held in the input register. The one exception is a tick that both shows
// a fade step and ends a pulse: the next step product for the new black
// target is rebuilt from the stored colour in the following cycle, and no word
// moves on from the input register in that cycle. A result is registered in
// the output register when its word moves on. Configuration writes take
// effect at once and must only be made while no word is in flight.
module rgb_fade_pulse_controller_core
    import rgbf_pkg::*;
#(
    parameter int unsigned FADE_STEPS = FADE_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int unsigned IW = $clog2(FADE_STEPS);
    localparam int unsigned PW = IW + 8;
    localparam logic [IW-1:0] LAST_IDX = IW'(FADE_STEPS - 1);

    // Configuration registers.
    logic [15:0] r_update_period;
    logic [15:0] r_pulse_duration;

    // Input and output registers.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // Fade state.
    logic [31:0]   r_now, n_now;
    logic [31:0]   r_update_stamp, n_update_stamp;
    logic [31:0]   r_pulse_stamp, n_pulse_stamp;
    t_rgb          r_start, n_start;
    t_rgb          r_target, n_target;
    t_rgb          r_shown, n_shown;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_reached, n_reached;
    logic          r_pulsing, n_pulsing;
    logic          n_updated;

    // Registered step products, magnitude and sign, one per channel. They
    // always match the stored index, start and target, except in the cycle
    // flagged by r_fix, when they are being rebuilt.
    logic [2:0][PW-1:0] r_mag, n_mag;
    logic [2:0]         r_neg, n_neg;
    logic               r_fix, n_fix;

    logic        w_adv;
    logic [31:0] w_now1;
    logic        w_upd_due;
    logic        w_pulse_due;
    logic        w_stepped;
    logic        w_expired;
    t_rgb        w_step;
    t_rgb        w_src_start;

    // A word moves from the input register to the output register when the
    // output slot is free or being emptied, unless a product rebuild is due.
    assign w_adv       = r_in_valid && !r_fix && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Elapsed times are unsigned 32-bit differences on the advanced clock.
    assign w_now1      = r_now + 32'd1;
    assign w_upd_due   = (w_now1 - r_update_stamp) >= {16'd0, r_update_period};
    assign w_pulse_due = (w_now1 - r_pulse_stamp) >= {16'd0, r_pulse_duration};

    for (genvar k = 0; k < 3; k++) begin : g_lerp
        rgbf_lerp #(
            .FADE_STEPS(FADE_STEPS)
        ) u_lerp (
            .i_start(r_start[k]),
            .i_mag  (r_mag[k]),
            .i_neg  (r_neg[k]),
            .o_value(w_step[k])
        );
    end

    always_comb begin
        n_now          = r_now;
        n_update_stamp = r_update_stamp;
        n_pulse_stamp  = r_pulse_stamp;
        n_start        = r_start;
        n_target       = r_target;
        n_shown        = r_shown;
        n_idx          = r_idx;
        n_reached      = r_reached;
        n_pulsing      = r_pulsing;
        n_updated      = 1'b0;
        w_stepped      = 1'b0;
        w_expired      = 1'b0;
        w_src_start    = r_start;
        if (w_adv) begin
            case (r_in.op)
                OP_TICK: begin
                    n_now = w_now1;
                    // The step check runs first, then the pulse expiry check.
                    if (w_upd_due) begin
                        n_update_stamp = w_now1;
                        if (!r_reached) begin
                            n_shown   = w_step;
                            n_updated = 1'b1;
                            w_stepped = 1'b1;
                            if (r_idx == LAST_IDX) begin
                                n_reached = 1'b1;
                                n_idx     = '0;
                            end else begin
                                n_idx = r_idx + IW'(1);
                            end
                        end
                    end
                    if (r_pulsing && w_pulse_due) begin
                        w_expired   = 1'b1;
                        n_target    = '0;
                        n_start     = n_shown;
                        w_src_start = r_shown;
                        n_reached   = 1'b0;
                        n_pulsing   = 1'b0;
                    end
                end
                OP_SET: begin
                    n_target    = {r_in.blue_in, r_in.green_in, r_in.red_in};
                    n_start     = r_shown;
                    w_src_start = r_shown;
                    n_reached   = 1'b0;
                end
                OP_PULSE: begin
                    n_target      = {r_in.blue_in, r_in.green_in, r_in.red_in};
                    n_start       = r_shown;
                    w_src_start   = r_shown;
                    n_reached     = 1'b0;
                    n_pulsing     = 1'b1;
                    n_pulse_stamp = r_now;
                end
                default: begin
                end
            endcase
        end
        // When a step and a pulse expiry share one tick, the new start is the
        // freshly interpolated colour; the product is rebuilt next cycle.
        n_fix = w_stepped && w_expired;
    end

    // Step products for the next step, taken from stored colours only.
    always_comb begin
        logic [7:0] absdiff;
        absdiff = '0;
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = n_target[k] < w_src_start[k];
            absdiff  = n_neg[k] ? (w_src_start[k] - n_target[k])
                                : (n_target[k] - w_src_start[k]);
            n_mag[k] = {{IW{1'b0}}, absdiff} * {8'd0, n_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_period  <= UPDATE_PERIOD_RST;
            r_pulse_duration <= PULSE_DURATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_UPDATE_PERIOD:  r_update_period  <= i_cfg_data;
                REG_PULSE_DURATION: r_pulse_duration <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now          <= '0;
            r_update_stamp <= '0;
            r_pulse_stamp  <= '0;
            r_start        <= '0;
            r_target       <= '0;
            r_shown        <= '0;
            r_idx          <= '0;
            r_reached      <= 1'b0;
            r_pulsing      <= 1'b0;
            r_mag          <= '0;
            r_neg          <= '0;
            r_fix          <= 1'b0;
        end else begin
            r_now          <= n_now;
            r_update_stamp <= n_update_stamp;
            r_pulse_stamp  <= n_pulse_stamp;
            r_start        <= n_start;
            r_target       <= n_target;
            r_shown        <= n_shown;
            r_idx          <= n_idx;
            r_reached      <= n_reached;
            r_pulsing      <= n_pulsing;
            r_mag          <= n_mag;
            r_neg          <= n_neg;
            r_fix          <= n_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.red_out      <= n_shown[0];
            r_out.green_out    <= n_shown[1];
            r_out.blue_out     <= n_shown[2];
            r_out.updated      <= n_updated;
            r_out.fade_done    <= n_reached;
            r_out.pulse_active <= n_pulsing;
        end
    end

    // A finished fade always parks the step index at zero.
    a_reached_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reached |-> (r_idx == '0))
        else $error("fade done with a nonzero step index");

    // At step index zero every stored step product must be zero.
    a_mag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx == '0) |-> (r_mag == '0))
        else $error("step product out of line with the step index");

    // A product rebuild lasts a single cycle.
    a_fix_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fix |=> !r_fix)
        else $error("product rebuild longer than one cycle");

    // A word that advances always lands in the output register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced word missing from the output register");

endmodule
